FILE: src/voice_cmd_queue_busy_handshake_top_assert.svh
// Assertion macros for the voice command queue top level.
// Expects signals clk and arst_n in the including scope.
`ifndef VOICE_CMD_QUEUE_BUSY_HANDSHAKE_TOP_ASSERT_SVH
`define VOICE_CMD_QUEUE_BUSY_HANDSHAKE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VCQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define VCQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/vcq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the voice command queue.
// No dependencies; imported by every module of the block.
package vcq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int MAX_TEXT    = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int LEN_LIMIT   = MAX_TEXT + 15;
	localparam int LEN_W       = 7;

	// command queue between front and back
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] OP_POLL = 2'd0;
	localparam logic [1:0] OP_ENQ  = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	localparam logic [1:0] PH_IDLE         = 2'd0;
	localparam logic [1:0] PH_WAIT_ASSERT  = 2'd1;
	localparam logic [1:0] PH_WAIT_RELEASE = 2'd2;

	localparam logic [LEN_W-1:0] CLEAR_LEN = LEN_W'(3);

	localparam logic REG_BUSY_LEVEL = 1'b0;
	localparam logic REG_TIMEOUT    = 1'b1;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] now_ms;
		logic        busy_pin;
		logic [15:0] msg_ref;
		logic [15:0] msg_len;
	} in_item_t;

	typedef struct packed {
		logic             send_valid;
		logic             send_kind;
		logic [15:0]      send_ref;
		logic [LEN_W-1:0] send_len;
		logic             push_ok;
		logic [1:0]       phase;
		logic             is_busy;
	} result_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [1:0]       op;
		logic [31:0]      now_ms;
		logic             pin_busy;
		logic [15:0]      msg_ref;
		logic [LEN_W-1:0] msg_len;
	} cmd_t;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
		return (i == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [FIFO_PTR_W-1:0] fifo_next(input logic [FIFO_PTR_W-1:0] i);
		return (i == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

FILE: src/vcq_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, resolves the busy level and clamps the length.
// Depends on vcq_pkg.
module vcq_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  vcq_pkg::in_item_t             item,
	input  logic                          busy_level,
	input  logic [vcq_pkg::FIFO_CNT_W-1:0] fifo_level,
	output logic                          busy,
	output logic                          cmd_valid,
	output vcq_pkg::cmd_t                 cmd
);
	import vcq_pkg::*;

	logic                 vld_s1;
	cmd_t                 cmd_s1;
	cmd_t                 cmd_d;
	logic [FIFO_CNT_W:0]  pending;
	logic                 accept;

	// count queued beats plus the one in this stage
	assign pending = {1'b0, fifo_level} + {{FIFO_CNT_W{1'b0}}, vld_s1};
	assign busy    = (pending >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
	assign accept  = start && !busy;

	// classify the incoming beat
	always_comb begin
		cmd_d.op       = item.opcode;
		cmd_d.now_ms   = item.now_ms;
		cmd_d.pin_busy = (item.busy_pin == busy_level);
		cmd_d.msg_ref  = item.msg_ref;
		cmd_d.msg_len  = (item.msg_len > 16'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
		                                                : item.msg_len[LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

endmodule

FILE: src/vcq_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the execution back end.
// Depends on vcq_pkg.
module vcq_cmd_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  vcq_pkg::cmd_t                  push_cmd,
	input  logic                           pop,
	output logic                           not_empty,
	output vcq_pkg::cmd_t                  head_cmd,
	output logic [vcq_pkg::FIFO_CNT_W-1:0] level
);
	import vcq_pkg::*;

	cmd_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_pop;

	assign not_empty = (cnt_q != '0);
	assign do_pop    = pop && not_empty;
	assign head_cmd  = mem_q[rd_ptr_q];
	assign level     = cnt_q;

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= fifo_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= fifo_next(rd_ptr_q);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: src/vcq_back.sv
`timescale 1ns / 1ps
// Back end: busy handshake phase machine, message ring and result register.
// Depends on vcq_pkg.
module vcq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  vcq_pkg::cmd_t     cmd,
	input  logic [15:0]       timeout_ms,
	output logic              done,
	output vcq_pkg::result_t  result
);
	import vcq_pkg::*;

	logic [1:0]       phase_q;
	logic [31:0]      start_ms_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [15:0]      ring_ref_q [QUEUE_DEPTH];
	logic [LEN_W-1:0] ring_len_q [QUEUE_DEPTH];
	logic             done_q;
	result_t          res_q;

	logic [1:0]       phase_d;
	logic [31:0]      start_ms_d;
	logic [PTR_W-1:0] head_d;
	logic [PTR_W-1:0] tail_d;
	logic             ring_wr;
	logic             try_send;
	logic             timed_out;
	logic [31:0]      elapsed;
	logic [PTR_W-1:0] tail_nxt;
	result_t          res_d;

	assign elapsed   = cmd.now_ms - start_ms_q;
	assign timed_out = (elapsed >= {16'd0, timeout_ms});
	assign tail_nxt  = ring_next(tail_q);

	// execute one command
	always_comb begin
		phase_d    = phase_q;
		start_ms_d = start_ms_q;
		head_d     = head_q;
		tail_d     = tail_q;
		ring_wr    = 1'b0;
		try_send   = 1'b0;
		res_d      = '0;
		case (cmd.op)
			OP_POLL: begin
				case (phase_q)
					PH_IDLE: begin
						if (cmd.pin_busy) begin
							phase_d    = PH_WAIT_RELEASE;
							start_ms_d = cmd.now_ms;
						end else begin
							try_send = 1'b1;
						end
					end
					PH_WAIT_ASSERT: begin
						if (cmd.pin_busy) begin
							phase_d = PH_WAIT_RELEASE;
						end else if (timed_out) begin
							phase_d  = PH_IDLE;
							try_send = 1'b1;
						end
					end
					PH_WAIT_RELEASE: begin
						if (!cmd.pin_busy) begin
							phase_d  = PH_IDLE;
							try_send = 1'b1;
						end
					end
					default: begin
						phase_d  = PH_IDLE;
						try_send = 1'b1;
					end
				endcase
				// send the next queued message
				if (try_send && (head_q != tail_q)) begin
					res_d.send_valid = 1'b1;
					res_d.send_ref   = ring_ref_q[head_q];
					res_d.send_len   = ring_len_q[head_q];
					head_d           = ring_next(head_q);
					start_ms_d       = cmd.now_ms;
					phase_d          = cmd.pin_busy ? PH_WAIT_RELEASE : PH_WAIT_ASSERT;
				end
			end
			OP_ENQ: begin
				if (tail_nxt != head_q) begin
					ring_wr       = 1'b1;
					tail_d        = tail_nxt;
					res_d.push_ok = 1'b1;
				end
			end
			OP_STOP: begin
				head_d           = tail_q;
				res_d.send_valid = 1'b1;
				res_d.send_kind  = 1'b1;
				res_d.send_len   = CLEAR_LEN;
				start_ms_d       = cmd.now_ms;
				phase_d          = cmd.pin_busy ? PH_WAIT_RELEASE : PH_IDLE;
			end
			default: begin
			end
		endcase
		res_d.phase   = phase_d;
		res_d.is_busy = cmd.pin_busy || (phase_d != PH_IDLE) || (head_d != tail_d);
	end

	// commit state and register the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			start_ms_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= go;
			if (go) begin
				phase_q    <= phase_d;
				start_ms_q <= start_ms_d;
				head_q     <= head_d;
				tail_q     <= tail_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res_d;
		end
		if (go && ring_wr) begin
			ring_ref_q[tail_q] <= cmd.msg_ref;
			ring_len_q[tail_q] <= cmd.msg_len;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: src/voice_cmd_queue_busy_handshake_top.sv
`timescale 1ns / 1ps
// Voice command queue with busy-pin handshake.
// A beat passes the front register, the command queue, then the done and result registers.
// Throughput: one item per cycle; the back end drains the 4-entry command queue every
// cycle, so the queue never holds more than one beat and busy stays low.
// Reset (arst_n low): phase idle, ring empty, level 0, timeout 100 ms.
module voice_cmd_queue_busy_handshake_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  vcq_pkg::in_item_t  item,
	output logic               done,
	output vcq_pkg::result_t   result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);
	import vcq_pkg::*;

	logic                  busy_level_q;
	logic [15:0]           timeout_q;
	logic                  front_valid;
	cmd_t                  front_cmd;
	logic                  fifo_not_empty;
	cmd_t                  fifo_head;
	logic [FIFO_CNT_W-1:0] fifo_level;

	assign cfg_ready = 1'b1;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_level_q <= 1'b0;
			timeout_q    <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BUSY_LEVEL: busy_level_q <= cfg_data[0];
				REG_TIMEOUT:    timeout_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	vcq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.busy_level (busy_level_q),
		.fifo_level (fifo_level),
		.busy       (busy),
		.cmd_valid  (front_valid),
		.cmd        (front_cmd)
	);

	vcq_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_cmd  (front_cmd),
		.pop       (1'b1),
		.not_empty (fifo_not_empty),
		.head_cmd  (fifo_head),
		.level     (fifo_level)
	);

	vcq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (fifo_not_empty),
		.cmd        (fifo_head),
		.timeout_ms (timeout_q),
		.done       (done),
		.result     (result)
	);

	`include "voice_cmd_queue_busy_handshake_top_assert.svh"

	`VCQ_ASSERT_NXT(a_accept_reaches_front, start && !busy, front_valid, "accepted beat lost")
	`VCQ_ASSERT_IMP(a_clear_shape, done && result.send_kind, result.send_valid && (result.send_len == CLEAR_LEN), "clear command malformed")
	`VCQ_ASSERT_IMP(a_push_no_send, done && result.push_ok, !result.send_valid, "enqueue also sent")
	`VCQ_ASSERT_IMP(a_phase_busy, done && (result.phase != PH_IDLE), result.is_busy, "active phase not reported busy")

endmodule

FILE: sim/voice_cmd_queue_busy_handshake_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the voice command queue: predicts one result per accepted
// command beat and checks it against the strobed result. Depends on vcq_pkg.
module voice_cmd_queue_busy_handshake_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  vcq_pkg::in_item_t item,
	input  logic              done,
	input  vcq_pkg::result_t  result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	output int                errors,
	output int                pending
);
	import vcq_pkg::*;

	// shadow copy of the block's settings and state
	logic                 level_q;
	logic [15:0]          timeout_q;
	logic [1:0]           phase_q;
	logic [31:0]          mark_ms;
	logic [PTR_W-1:0]     rd_ptr;
	logic [PTR_W-1:0]     wr_ptr;
	logic [15:0]          slot_ref [QUEUE_DEPTH];
	logic [LEN_W-1:0]     slot_len [QUEUE_DEPTH];

	result_t              sent_q[$];
	result_t              want_r;
	int                   fail_cnt = 0;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return PTR_W'((int'(p) + 1) % QUEUE_DEPTH);
	endfunction

	// advance the shadow state by one command and return the result it gives
	function automatic result_t run_command(input in_item_t it);
		result_t     r;
		logic        pin_busy;
		logic        try_send;
		logic [31:0] elapsed;
		r = '0;
		pin_busy = (it.busy_pin == level_q);
		try_send = 1'b0;
		elapsed = it.now_ms - mark_ms;
		case (it.opcode)
		OP_POLL: begin
			case (phase_q)
			PH_IDLE: begin
				if (pin_busy) begin
					phase_q = PH_WAIT_RELEASE;
					mark_ms = it.now_ms;
				end else begin
					try_send = 1'b1;
				end
			end
			PH_WAIT_ASSERT: begin
				if (pin_busy) begin
					phase_q = PH_WAIT_RELEASE;
				end else if (elapsed >= {16'd0, timeout_q}) begin
					phase_q = PH_IDLE;
					try_send = 1'b1;
				end
			end
			PH_WAIT_RELEASE: begin
				if (!pin_busy) begin
					phase_q = PH_IDLE;
					try_send = 1'b1;
				end
			end
			default: begin
				phase_q = PH_IDLE;
				try_send = 1'b1;
			end
			endcase
			// dequeue the next message when the handshake allows it
			if (try_send && rd_ptr != wr_ptr) begin
				r.send_valid = 1'b1;
				r.send_ref = slot_ref[rd_ptr];
				r.send_len = slot_len[rd_ptr];
				rd_ptr = bump(rd_ptr);
				mark_ms = it.now_ms;
				phase_q = pin_busy ? PH_WAIT_RELEASE : PH_WAIT_ASSERT;
			end
		end
		OP_ENQ: begin
			// keep one slot free to tell full from empty
			if (bump(wr_ptr) != rd_ptr) begin
				slot_ref[wr_ptr] = it.msg_ref;
				slot_len[wr_ptr] = (it.msg_len > 16'(LEN_LIMIT)) ?
					LEN_W'(LEN_LIMIT) : it.msg_len[LEN_W-1:0];
				wr_ptr = bump(wr_ptr);
				r.push_ok = 1'b1;
			end
		end
		OP_STOP: begin
			rd_ptr = wr_ptr;
			r.send_valid = 1'b1;
			r.send_kind = 1'b1;
			r.send_len = CLEAR_LEN;
			mark_ms = it.now_ms;
			phase_q = pin_busy ? PH_WAIT_RELEASE : PH_IDLE;
		end
		default: begin
		end
		endcase
		r.phase = phase_q;
		r.is_busy = pin_busy || phase_q != PH_IDLE || rd_ptr != wr_ptr;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q = 1'b0;
			timeout_q = TIMEOUT_RESET;
			phase_q = PH_IDLE;
			mark_ms = '0;
			rd_ptr = '0;
			wr_ptr = '0;
			sent_q.delete();
		end else begin
			// match the strobed result against the oldest prediction
			if (done) begin
				if (sent_q.size() == 0) begin
					if (fail_cnt < 10)
						$display("[%0t] result with nothing predicted: v%0d k%0d ref %h len %0d",
							$time, result.send_valid, result.send_kind,
							result.send_ref, result.send_len);
					fail_cnt++;
				end else begin
					want_r = sent_q.pop_front();
					if (result.send_valid !== want_r.send_valid ||
					    result.send_kind !== want_r.send_kind ||
					    result.send_ref !== want_r.send_ref ||
					    result.send_len !== want_r.send_len ||
					    result.push_ok !== want_r.push_ok ||
					    result.phase !== want_r.phase ||
					    result.is_busy !== want_r.is_busy) begin
						if (fail_cnt < 10)
							$display({"[%0t] result mismatch: expected v%0d k%0d ref %h len %0d",
								" ok%0d ph%0d busy%0d, got v%0d k%0d ref %h len %0d ok%0d",
								" ph%0d busy%0d"}, $time,
								want_r.send_valid, want_r.send_kind, want_r.send_ref,
								want_r.send_len, want_r.push_ok, want_r.phase,
								want_r.is_busy, result.send_valid, result.send_kind,
								result.send_ref, result.send_len, result.push_ok,
								result.phase, result.is_busy);
						fail_cnt++;
					end
				end
			end
			// track register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BUSY_LEVEL)
					level_q = cfg_data[0];
				else
					timeout_q = cfg_data;
			end
			// predict each accepted command beat
			if (start && !busy)
				sent_q.push_back(run_command(item));
		end
		errors <= fail_cnt;
		pending <= sent_q.size();
	end

endmodule

FILE: sim/voice_cmd_queue_busy_handshake_top_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the voice command queue top level: directed and
// random command beats under several settings. Depends on vcq_pkg and the checker.
module voice_cmd_queue_busy_handshake_top_test;
	import vcq_pkg::*;

	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         PHASE_ITEMS  = 105;
	localparam logic [1:0] OP_UNUSED    = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_item_t    item = '0;
	logic        done;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	int          errors;
	int          pending;
	int          cycles = 0;
	int          burst_left = 0;
	int          beats = 0;
	logic [31:0] wall_ms = '0;
	logic        pin_level = 1'b1;

	voice_cmd_queue_busy_handshake_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	voice_cmd_queue_busy_handshake_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// give up if the run hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic in_item_t make_item(input logic [1:0] op, input logic [31:0] now,
		input logic pin, input logic [15:0] ref_id, input logic [15:0] len);
		in_item_t it;
		it.opcode = op;
		it.now_ms = now;
		it.busy_pin = pin;
		it.msg_ref = ref_id;
		it.msg_len = len;
		return it;
	endfunction

	// lengths mostly around the clamp point, sometimes anywhere
	function automatic logic [15:0] msg_length();
		return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 90));
	endfunction

	// move the clock on, with rare long jumps, and let the pin wander
	function automatic void tick();
		case ($urandom_range(0, 39))
		0: wall_ms = $urandom;
		1, 2: wall_ms = wall_ms + $urandom_range(0, 70000);
		default: wall_ms = wall_ms + $urandom_range(0, 25);
		endcase
		if ($urandom_range(0, 3) == 0)
			pin_level = ~pin_level;
	endfunction

	// hand one command beat to the block; random bursts with random gaps
	task automatic drive_item(input in_item_t it);
		int gap;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		if (it.opcode != OP_UNUSED)
			beats++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ?
				$urandom_range(30, 60) : $urandom_range(0, 15);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// drop start and wait until every predicted result has come back
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write both registers back to back, holding valid across the two beats
	task automatic load_settings(input logic lvl, input logic [15:0] tmo);
		cfg_valid <= 1'b1;
		cfg_index <= REG_BUSY_LEVEL;
		cfg_data <= {15'd0, lvl};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_TIMEOUT;
		cfg_data <= tmo;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// mostly queue-then-drain sessions; the rest is noise with any opcode
	task automatic run_session();
		int          k;
		logic [1:0]  op;
		if ($urandom_range(0, 4) != 0) begin
			k = $urandom_range(1, 8);
			repeat (k) begin
				tick();
				drive_item(make_item(OP_ENQ, wall_ms, pin_level, 16'($urandom),
					msg_length()));
			end
			repeat (k * 3 + $urandom_range(0, 6)) begin
				tick();
				op = ($urandom_range(0, 15) == 0) ? OP_STOP : OP_POLL;
				drive_item(make_item(op, wall_ms, pin_level, 16'($urandom),
					msg_length()));
			end
		end else begin
			repeat ($urandom_range(1, 10)) begin
				tick();
				pin_level = 1'($urandom);
				drive_item(make_item(2'($urandom), wall_ms, pin_level, 16'($urandom),
					msg_length()));
			end
		end
	endtask

	initial begin
		logic        lvl_set [6];
		logic [15:0] tmo_set [6];
		lvl_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		tmo_set = '{16'd1, 16'd65535, 16'd0, 16'($urandom_range(2, 3000)), 16'd100,
			16'($urandom_range(1, 65535))};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats at reset settings: level 0 means pin low is busy
		drive_item(make_item(OP_POLL, 32'd0, 1'b1, 16'h0000, 16'h0000));
		drive_item(make_item(OP_ENQ, 32'd1, 1'b1, 16'hFFFF, 16'hFFFF));
		drive_item(make_item(OP_ENQ, 32'd2, 1'b1, 16'h0000, 16'h0000));
		drive_item(make_item(OP_ENQ, 32'd3, 1'b1, 16'h1234, 16'd80));
		drive_item(make_item(OP_ENQ, 32'd4, 1'b1, 16'h5678, 16'd79));
		drive_item(make_item(OP_ENQ, 32'd5, 1'b1, 16'hAAAA, 16'd1));
		drive_item(make_item(OP_ENQ, 32'd6, 1'b1, 16'h5555, 16'd65));
		drive_item(make_item(OP_ENQ, 32'd7, 1'b1, 16'h00FF, 16'd7));
		// ring is full now: this one is refused
		drive_item(make_item(OP_ENQ, 32'd8, 1'b1, 16'hDEAD, 16'd16));
		drive_item(make_item(OP_POLL, 32'd10, 1'b1, 16'h0000, 16'h0000));
		drive_item(make_item(OP_POLL, 32'd60, 1'b1, 16'h0000, 16'h0000));
		drive_item(make_item(OP_POLL, 32'd61, 1'b0, 16'h0000, 16'h0000));
		drive_item(make_item(OP_POLL, 32'd70, 1'b0, 16'h0000, 16'h0000));
		drive_item(make_item(OP_POLL, 32'd80, 1'b1, 16'h0000, 16'h0000));
		// busy never shows up: time out and send the next one
		drive_item(make_item(OP_POLL, 32'd180, 1'b1, 16'h0000, 16'h0000));
		drive_item(make_item(OP_UNUSED, 32'd190, 1'b0, 16'hFFFF, 16'hFFFF));
		drive_item(make_item(OP_POLL, 32'd200, 1'b0, 16'h0000, 16'h0000));
		drive_item(make_item(OP_STOP, 32'd210, 1'b0, 16'h0000, 16'h0000));
		drive_item(make_item(OP_POLL, 32'd220, 1'b1, 16'h0000, 16'h0000));
		// elapsed time across the 32-bit wrap
		drive_item(make_item(OP_ENQ, 32'd230, 1'b1, 16'hBEEF, 16'd32));
		drive_item(make_item(OP_POLL, 32'hFFFF_FFF0, 1'b1, 16'h0000, 16'h0000));
		drive_item(make_item(OP_POLL, 32'h0000_0053, 1'b1, 16'h0000, 16'h0000));
		drive_item(make_item(OP_POLL, 32'h0000_0054, 1'b1, 16'h0000, 16'h0000));
		drive_item(make_item(OP_POLL, 32'h0000_0055, 1'b0, 16'h0000, 16'h0000));
		drive_item(make_item(OP_STOP, 32'h0000_0060, 1'b1, 16'h0000, 16'h0000));

		// random sessions, one block of them per register setting
		wall_ms = 32'hFFFF_FE00;
		for (int i = 0; i < 6; i++) begin
			settle();
			load_settings(lvl_set[i], tmo_set[i]);
			beats = 0;
			while (beats < PHASE_ITEMS)
				run_session();
		end

		settle();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
